// ----- sv/rrwl_pkg.sv -----
// Package with the shared constants and types of the wear-leveled nonce store.
`timescale 1ns / 1ps

package rrwl_pkg;

    localparam int NUM_SECTORS    = 512;
    localparam int IDX_W          = $clog2(NUM_SECTORS);
    localparam int NONCE_W        = 64;
    localparam int OPCODE_W       = 2;
    localparam int SECTOR_INDEX_W = 9;
    localparam int ENTRY_W        = 2 * NONCE_W;

    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_INCR  = 2'd2;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [NONCE_W-1:0] word_t;

    typedef struct packed {
        word_t counter;
        word_t nonce;
    } entry_t;

endpackage

// ----- sv/rrwl_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module rrwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/round_robin_wear_level_nonce_store.sv -----
// Top level of the round-robin wear-leveled nonce store.
//
//   Channel   Ports                                      Handshake
//   command   start, opcode, new_nonce / busy            taken when start && !busy
//   result    done, nonce_value, sector_index, write_count  one-cycle strobe on done
//
// After reset a clearing pass writes zero to all NUM_SECTORS entries
// while busy is high.
// A command passes through the states FIRST, SCAN and ACT while busy is high: one RAM read
// per sector while scanning the counters for the current sector, then the acting state.
// The result strobe comes in the cycle after the acting state, as busy falls.
// The receiver cannot stall; a new command may be taken in the cycle of the strobe.
`timescale 1ns / 1ps

module round_robin_wear_level_nonce_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [rrwl_pkg::OPCODE_W-1:0]        opcode,
    input  logic [rrwl_pkg::NONCE_W-1:0]         new_nonce,
    output logic                                 busy,
    output logic                                 done,
    output logic [rrwl_pkg::NONCE_W-1:0]         nonce_value,
    output logic [rrwl_pkg::SECTOR_INDEX_W-1:0]  sector_index,
    output logic [rrwl_pkg::NONCE_W-1:0]         write_count
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FIRST = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_ACT   = 3'd4;

    localparam rrwl_pkg::idx_t LAST_IDX = rrwl_pkg::IDX_W'(rrwl_pkg::NUM_SECTORS - 1);

    logic [2:0]                        state_reg, state_next;
    rrwl_pkg::idx_t                    idx_reg, idx_next;
    rrwl_pkg::entry_t                  prev_reg, prev_next;
    logic [rrwl_pkg::OPCODE_W-1:0]     op_reg, op_next;
    rrwl_pkg::word_t                   arg_reg, arg_next;
    logic                              done_reg, done_next;
    rrwl_pkg::word_t                   nonce_reg, nonce_next;
    rrwl_pkg::idx_t                    sidx_reg, sidx_next;
    rrwl_pkg::word_t                   count_reg, count_next;

    logic                              ram_we;
    rrwl_pkg::idx_t                    ram_addr;
    rrwl_pkg::entry_t                  ram_wdata;
    rrwl_pkg::entry_t                  ram_rdata;

    rrwl_pkg::idx_t                    nidx;
    rrwl_pkg::idx_t                    store_idx;
    rrwl_pkg::word_t                   store_val;
    logic [rrwl_pkg::IDX_W+rrwl_pkg::SECTOR_INDEX_W-1:0] sidx_wide;

    rrwl_ram #(
        .WIDTH (rrwl_pkg::ENTRY_W),
        .DEPTH (rrwl_pkg::NUM_SECTORS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign nidx      = idx_reg + 1'b1;
    assign store_idx = (idx_reg == LAST_IDX) ? '0 : nidx;
    assign store_val = (op_reg == rrwl_pkg::OP_WRITE) ? arg_reg : prev_reg.nonce + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        op_next    = op_reg;
        arg_next   = arg_reg;
        done_next  = 1'b0;
        nonce_next = nonce_reg;
        sidx_next  = sidx_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_addr   = '0;
        ram_wdata  = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = idx_reg;
                idx_next = nidx;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_addr = '0;
                if (start)
                begin
                    op_next    = opcode;
                    arg_next   = new_nonce;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                prev_next  = ram_rdata;
                idx_next   = '0;
                ram_addr   = rrwl_pkg::IDX_W'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (ram_rdata.counter <= prev_reg.counter)
                begin
                    state_next = ST_ACT;
                end
                else
                begin
                    prev_next = ram_rdata;
                    idx_next  = nidx;
                    if (nidx == LAST_IDX)
                    begin
                        state_next = ST_ACT;
                    end
                    else
                    begin
                        ram_addr = nidx + 1'b1;
                    end
                end
            end
            ST_ACT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == rrwl_pkg::OP_WRITE || op_reg == rrwl_pkg::OP_INCR)
                begin
                    ram_we            = 1'b1;
                    ram_addr          = store_idx;
                    ram_wdata.counter = prev_reg.counter + 1'b1;
                    ram_wdata.nonce   = store_val;
                    nonce_next        = store_val;
                    sidx_next         = store_idx;
                    count_next        = prev_reg.counter + 1'b1;
                end
                else
                begin
                    nonce_next = prev_reg.nonce;
                    sidx_next  = idx_reg;
                    count_next = prev_reg.counter;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        op_reg    <= op_next;
        arg_reg   <= arg_next;
        nonce_reg <= nonce_next;
        sidx_reg  <= sidx_next;
        count_reg <= count_next;
    end

    assign sidx_wide    = {{rrwl_pkg::SECTOR_INDEX_W{1'b0}}, sidx_reg};
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign nonce_value  = nonce_reg;
    assign sector_index = sidx_wide[rrwl_pkg::SECTOR_INDEX_W-1:0];
    assign write_count  = count_reg;

endmodule

// ----- dv/nonce_store_checker.sv -----
// Checker that predicts and compares every result of the wear-leveled nonce store.
`timescale 1ns / 1ps

module nonce_store_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [rrwl_pkg::OPCODE_W-1:0]        opcode,
    input  rrwl_pkg::word_t                      new_nonce,
    input  logic                                 done,
    input  rrwl_pkg::word_t                      nonce_value,
    input  logic [rrwl_pkg::SECTOR_INDEX_W-1:0]  sector_index,
    input  rrwl_pkg::word_t                      write_count,
    output int                                   failures,
    output int                                   outstanding
);

    typedef struct packed {
        rrwl_pkg::word_t                      nonce;
        logic [rrwl_pkg::SECTOR_INDEX_W-1:0]  sector;
        rrwl_pkg::word_t                      count;
    } sector_report_t;

    rrwl_pkg::word_t model_counts [rrwl_pkg::NUM_SECTORS];
    rrwl_pkg::word_t model_nonces [rrwl_pkg::NUM_SECTORS];
    sector_report_t  awaited_reports [$];
    int              error_total;

    function automatic int current_sector();
        for (int i = 0; i + 1 < rrwl_pkg::NUM_SECTORS; i++)
        begin
            if (model_counts[i + 1] <= model_counts[i])
            begin
                return i;
            end
        end
        return rrwl_pkg::NUM_SECTORS - 1;
    endfunction

    // Applies one command to the model and returns the report it must produce.
    function automatic sector_report_t apply_command(
        input logic [rrwl_pkg::OPCODE_W-1:0] op,
        input rrwl_pkg::word_t               value
    );
        int             cur;
        int             nxt;
        sector_report_t rep;
        cur = current_sector();
        if (op == rrwl_pkg::OP_WRITE || op == rrwl_pkg::OP_INCR)
        begin
            rep.nonce = (op == rrwl_pkg::OP_WRITE) ? value
                      : rrwl_pkg::word_t'(model_nonces[cur] + 64'd1);
            nxt = (cur + 1) % rrwl_pkg::NUM_SECTORS;
            model_counts[nxt] = rrwl_pkg::word_t'(model_counts[cur] + 64'd1);
            model_nonces[nxt] = rep.nonce;
        end
        else
        begin
            rep.nonce = model_nonces[cur];
            nxt = cur;
        end
        rep.sector = rrwl_pkg::SECTOR_INDEX_W'(nxt);
        rep.count  = model_counts[nxt];
        return rep;
    endfunction

    function automatic int field_mismatch(input string label, input rrwl_pkg::word_t want,
                                          input rrwl_pkg::word_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sector_report_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < rrwl_pkg::NUM_SECTORS; k++)
            begin
                model_counts[k] = '0;
                model_nonces[k] = '0;
            end
            awaited_reports.delete();
            error_total = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h",
                             $time, nonce_value, sector_index, write_count);
                    error_total++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    error_total += field_mismatch("nonce_value", want.nonce, nonce_value);
                    error_total += field_mismatch("sector_index",
                                                  rrwl_pkg::word_t'(want.sector),
                                                  rrwl_pkg::word_t'(sector_index));
                    error_total += field_mismatch("write_count", want.count, write_count);
                end
            end
            if (start && !busy)
            begin
                awaited_reports.push_back(apply_command(opcode, new_nonce));
            end
            outstanding <= awaited_reports.size();
            failures    <= error_total;
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the testbench: clock, reset, command stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
    import rrwl_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_COMMANDS = 1140;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic [OPCODE_W-1:0]        opcode;
    word_t                      new_nonce;
    logic                       busy;
    logic                       done;
    word_t                      nonce_value;
    logic [SECTOR_INDEX_W-1:0]  sector_index;
    word_t                      write_count;
    int                         failures;
    int                         outstanding;

    always #5 clk = ~clk;

    round_robin_wear_level_nonce_store dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .new_nonce    (new_nonce),
        .busy         (busy),
        .done         (done),
        .nonce_value  (nonce_value),
        .sector_index (sector_index),
        .write_count  (write_count)
    );

    nonce_store_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .new_nonce    (new_nonce),
        .done         (done),
        .nonce_value  (nonce_value),
        .sector_index (sector_index),
        .write_count  (write_count),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    function automatic word_t random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 80);
    endfunction

    // Drives start high and holds it until busy is low, then idles for the given gap.
    task automatic issue(input logic [OPCODE_W-1:0] op, input word_t value, input int gap);
        start     <= 1'b1;
        opcode    <= op;
        new_nonce <= value;
        @(posedge clk);
        while (busy) begin
            @(posedge clk);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    initial begin : stimulus
        int               roll;
        logic [OPCODE_W-1:0] op;
        word_t            value;
        int               gap;
        rst_n     = 1'b0;
        start     <= 1'b0;
        opcode    <= OP_READ;
        new_nonce <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        issue(OP_READ, '0, 0);
        issue(OP_INCR, random_word(), 2);
        issue(OP_WRITE, '1, 0);
        issue(OP_READ, random_word(), 1);
        issue(OP_INCR, '0, 0);
        issue(OP_WRITE, '0, 3);
        issue(OP_INCR, '1, 0);
        issue(OP_SPARE, random_word(), 0);
        issue(OP_WRITE, 64'h5555_5555_5555_5555, 0);
        issue(OP_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 1);
        issue(OP_READ, '1, 0);
        issue(OP_WRITE, 64'h8000_0000_0000_0000, 0);
        issue(OP_INCR, '0, 0);
        issue(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFE, 0);
        issue(OP_INCR, '0, 0);
        issue(OP_INCR, '0, 5);
        issue(OP_SPARE, '1, 0);
        issue(OP_READ, '0, 0);
        issue(OP_WRITE, random_word(), 0);
        issue(OP_READ, random_word(), 0);
        drain();

        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                op = OP_WRITE;
            end
            else if (roll < 70) begin
                op = OP_INCR;
            end
            else if (roll < 90) begin
                op = OP_READ;
            end
            else begin
                op = OP_SPARE;
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                value = '1;
            end
            else if (roll < 8) begin
                value = '0;
            end
            else begin
                value = random_word();
            end
            // Every fourth stretch of 64 transactions runs back to back.
            gap = ((n / 64) % 4 == 1) ? 0 : random_gap();
            issue(op, value, gap);
            if ($urandom_range(0, 99) < 2) begin
                drain();
            end
        end

        drain();
        repeat (NUM_SECTORS + 8) @(posedge clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- round_robin_wear_level_nonce_store.f -----
sv/rrwl_pkg.sv
sv/rrwl_ram.sv
sv/round_robin_wear_level_nonce_store.sv
dv/nonce_store_checker.sv
dv/testbench.sv
